[sv/rcc_pkg.sv]
// shared constants, op codes and controller/datapath interface types
`default_nettype none
package rcc_pkg;

  localparam int IDX_W      = 16;
  localparam int DIST_W     = 32;
  localparam int LIMIT_W    = 17;
  localparam int COUNT_W    = 16;
  localparam int OP_W       = 2;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = LIMIT_W + DIST_W;
  localparam int PAIR_W     = 2 * IDX_W;

  // in tdata: query, train, has_two, best, second, zero pad to bytes
  localparam int IN_FIELDS_W  = 2 * IDX_W + 1 + 2 * DIST_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  // out tdata: kept, query, train, dist, count, zero pad to bytes
  localparam int OUT_FIELDS_W = 1 + 2 * IDX_W + DIST_W + COUNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(52429);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

  typedef struct packed {
    logic capture;
    logic mul;
    logic clear;
    logic store;
    logic scan_issue;
    logic emit;
  } rcc_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            pass;
    logic            full;
    logic            more;
    logic            rd_pend;
    logic            hit;
    logic            out_free;
  } rcc_sts_t;

endpackage
`default_nettype wire

[sv/ratio_and_cross_check_match_filter.sv]
// top level of the ratio test and cross check match filter
`default_nettype none
// Filters feature matches with a ratio test and a symmetry (cross) check.
// Each input beat carries an op in in_tuser: clear empties the pair table
// and zeroes the kept count, load stores a passing reverse candidate as a
// (query, train) pair, check tests a forward candidate and always returns
// one output beat. A candidate passes the ratio test when has_two is set
// and best_dist * 65536 <= ratio_limit * second_dist; a forward candidate
// is kept when it passes and a stored pair has the swapped indices.
// Timing: the block works on one item at a time. Clear and load pass through
// capture, a 17x32 multiply, and compare and dispatch before the next in_tready.
// A passing check walks the table through its single read port, one entry a
// cycle, and stops at the first hit or once all stored pairs are read (at once
// on an empty table); a failing check goes from compare straight to emit.
// The output register lets the next item be accepted while a result waits
// for out_tready; a further result then holds the block until that beat
// leaves.
// The table contents are not cleared; only entries below the fill count are
// read, so no clearing pass follows reset.
module ratio_and_cross_check_match_filter #(
  parameter int TABLE_DEPTH = rcc_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // in_tdata, from bit 0: query_idx[15:0], train_idx[31:16], has_two[32],
  // best_dist[64:33], second_dist[96:65], zero pad
  input  wire logic [rcc_pkg::IN_DATA_W-1:0] in_tdata,
  // in_tuser: op[1:0]
  input  wire logic [rcc_pkg::OP_W-1:0]      in_tuser,
  // result channel
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // out_tdata, from bit 0: kept[0], out_query[16:1], out_train[32:17],
  // out_dist[64:33], kept_count[80:65], zero pad
  output logic [rcc_pkg::OUT_DATA_W-1:0]     out_tdata,
  // ratio_limit register, unsigned Q1.16
  input  wire logic                          cfg_wr_en,
  input  wire logic [rcc_pkg::LIMIT_W-1:0]   cfg_wr_data
);

  rcc_pkg::rcc_cmd_t cmd;
  rcc_pkg::rcc_sts_t sts;

  // state machine sequencing each item
  rcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // registers, multiplier, pair table and output stage
  rcc_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts)
  );

  // an accepted beat always occupies the block for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted on two consecutive cycles");

  // a pair is stored only when it passes and the table has room
  a_store_guard: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> (sts.pass && !sts.full))
    else $error("pair stored into a full table or without passing");

  // a result is loaded only into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("result overwrote a pending output beat");

  // a table read is never issued once a hit has been seen
  a_no_read_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    sts.hit |-> !cmd.scan_issue)
    else $error("table read issued after a hit");

endmodule
`default_nettype wire

[sv/rcc_ctrl.sv]
// sequencing controller: capture, multiply, dispatch, table scan, emit
`default_nettype none
module rcc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire rcc_pkg::rcc_sts_t sts,
  output rcc_pkg::rcc_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        case (sts.op)
          rcc_pkg::OP_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end
          rcc_pkg::OP_LOAD: begin
            cmd.store = sts.pass && !sts.full;
            state_nxt = S_IDLE;
          end
          rcc_pkg::OP_CHECK: begin
            state_nxt = sts.pass ? S_SCAN : S_DONE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.hit) begin
          state_nxt = S_DONE;
        end else if (sts.more) begin
          cmd.scan_issue = 1'b1;
        end else if (!sts.rd_pend) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/rcc_datapath.sv]
// item registers, ratio multiplier, pair table, scan counter, output register
`default_nettype none
module rcc_datapath #(
  parameter int TABLE_DEPTH = rcc_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [rcc_pkg::OP_W-1:0]          in_tuser,
  input  wire logic [rcc_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [rcc_pkg::OUT_DATA_W-1:0]         out_tdata,
  input  wire logic                              cfg_wr_en,
  input  wire logic [rcc_pkg::LIMIT_W-1:0]       cfg_wr_data,
  input  wire rcc_pkg::rcc_cmd_t                 cmd,
  output rcc_pkg::rcc_sts_t                      sts
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = rcc_pkg::IDX_W;
  localparam int DW = rcc_pkg::DIST_W;

  logic [rcc_pkg::OP_W-1:0]    op_r;
  logic [IW-1:0]               q_r;
  logic [IW-1:0]               t_r;
  logic                        two_r;
  logic [DW-1:0]               best_r;
  logic [DW-1:0]               second_r;
  logic [rcc_pkg::PROD_W-1:0]  prod_r;
  logic [rcc_pkg::LIMIT_W-1:0] limit_r;
  logic [CW-1:0]               pair_count_r;
  logic [CW-1:0]               scan_idx_r;
  logic                        rd_pend_r;
  logic [rcc_pkg::PAIR_W-1:0]  rd_data_r;
  logic                        found_r;
  logic [rcc_pkg::COUNT_W-1:0] total_r;
  logic [rcc_pkg::COUNT_W-1:0] total_nxt;
  logic                        out_tvalid_r;
  logic [rcc_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic [rcc_pkg::PROD_W-1:0]  lhs;
  logic                        hit;

  logic [rcc_pkg::PAIR_W-1:0]  pair_mem [TABLE_DEPTH];

  // best * 2^16, widened to the product width
  assign lhs = {1'b0, best_r, {rcc_pkg::FRAC_W{1'b0}}};
  // stored pair is {train, query}: stored train must equal query, stored query train
  assign hit = rd_pend_r && (rd_data_r[IW-1:0] == t_r) && (rd_data_r[2*IW-1:IW] == q_r);

  always_comb begin
    total_nxt = total_r;
    if (found_r && (total_r != rcc_pkg::COUNT_MAX)) begin
      total_nxt = total_r + 1'b1;
    end
  end

  always_comb begin
    sts          = '0;
    sts.op       = op_r;
    sts.pass     = two_r && (lhs <= prod_r);
    sts.full     = (pair_count_r == CW'(TABLE_DEPTH));
    sts.more     = (scan_idx_r < pair_count_r);
    sts.rd_pend  = rd_pend_r;
    sts.hit      = hit;
    sts.out_free = !out_tvalid_r || out_tready;
  end

  // item capture and multiplier
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_tuser;
      q_r      <= in_tdata[IW-1:0];
      t_r      <= in_tdata[2*IW-1:IW];
      two_r    <= in_tdata[2*IW];
      best_r   <= in_tdata[2*IW+DW:2*IW+1];
      second_r <= in_tdata[2*IW+2*DW:2*IW+DW+1];
    end
    if (cmd.mul) begin
      prod_r <= limit_r * second_r;
    end
  end

  // pair table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      pair_mem[pair_count_r[AW-1:0]] <= {t_r, q_r};
    end
    if (cmd.scan_issue) begin
      rd_data_r <= pair_mem[scan_idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= rcc_pkg::LIMIT_RESET;
      pair_count_r <= '0;
      scan_idx_r   <= '0;
      rd_pend_r    <= 1'b0;
      found_r      <= 1'b0;
      total_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (cmd.clear) begin
        pair_count_r <= '0;
      end else if (cmd.store) begin
        pair_count_r <= pair_count_r + 1'b1;
      end
      if (cmd.capture) begin
        scan_idx_r <= '0;
      end else if (cmd.scan_issue) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      rd_pend_r <= cmd.scan_issue;
      if (cmd.capture) begin
        found_r <= 1'b0;
      end else if (hit) begin
        found_r <= 1'b1;
      end
      if (cmd.clear) begin
        total_r <= '0;
      end else if (cmd.emit) begin
        total_r <= total_nxt;
      end
      if (cmd.emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tdata_r <= rcc_pkg::OUT_DATA_W'({total_nxt, best_r, t_r, q_r, found_r});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire
